FILE: rtl/core/utf8v_pkg.sv
// Package for the strict UTF-8 validator/sanitizer: item types, codes,
// byte constants and the sequence classification functions.
// No dependencies.
package utf8v_pkg;

    localparam logic [7:0] LEAD2_LO   = 8'hC2;
    localparam logic [7:0] LEAD2_HI   = 8'hDF;
    localparam logic [7:0] LEAD3_LO   = 8'hE0;
    localparam logic [7:0] LEAD3_SURR = 8'hED;
    localparam logic [7:0] LEAD4_HI   = 8'hF4;
    localparam logic [7:0] LEAD4_LO   = 8'hF0;
    localparam logic [7:0] CONT_LO    = 8'h80;
    localparam logic [7:0] CONT_HI    = 8'hBF;
    localparam logic [7:0] E0_SEC_LO  = 8'hA0;
    localparam logic [7:0] ED_SEC_HI  = 8'h9F;
    localparam logic [7:0] F0_SEC_LO  = 8'h90;
    localparam logic [7:0] F4_SEC_HI  = 8'h8F;
    localparam logic [7:0] REPL_B0    = 8'hEF;
    localparam logic [7:0] REPL_B1    = 8'hBF;
    localparam logic [7:0] REPL_B2    = 8'hBD;

    localparam int BUF_DEPTH = 4;  // held bytes plus the incoming one

    // byte with its lead class (0 = cannot lead)
    typedef struct packed {
        logic [7:0] data;
        logic [2:0] len;
    } entry_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic [2:0] len;
    } item_t;

    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_HOLD,
        ACT_REPL,
        ACT_PASS
    } act_e;

    typedef struct packed {
        act_e       act;
        logic [2:0] n;
    } scan_t;

    typedef enum logic [1:0] {
        ST_SCAN,
        ST_REP1,
        ST_REP2,
        ST_PASS
    } st_e;

    function automatic logic [2:0] lead_length(input logic [7:0] b);
        logic [2:0] n;
        n = 3'd0;
        if (b < CONT_LO) n = 3'd1;
        else if (b >= LEAD2_LO && b <= LEAD2_HI) n = 3'd2;
        else if (b >= LEAD3_LO && b <= REPL_B0) n = 3'd3;
        else if (b >= LEAD4_LO && b <= LEAD4_HI) n = 3'd4;
        return n;
    endfunction

    function automatic logic follower_ok(input logic [7:0] lead, input logic [1:0] k,
                                         input logic [7:0] b);
        logic ok;
        ok = (b >= CONT_LO) && (b <= CONT_HI);
        if (k == 2'd1) begin
            if (lead == LEAD3_LO) ok = (b >= E0_SEC_LO) && (b <= CONT_HI);
            else if (lead == LEAD3_SURR) ok = (b >= CONT_LO) && (b <= ED_SEC_HI);
            else if (lead == LEAD4_LO) ok = (b >= F0_SEC_LO) && (b <= CONT_HI);
            else if (lead == LEAD4_HI) ok = (b >= CONT_LO) && (b <= F4_SEC_HI);
        end
        return ok;
    endfunction

    // what to do with the sequence starting at w[0], c entries valid
    function automatic scan_t classify(input entry_t [BUF_DEPTH-1:0] w,
                                       input logic [2:0] c, input logic last);
        scan_t      r;
        logic [2:0] n;
        logic [2:0] m;
        logic       ok;
        n      = w[0].len;
        m      = (n < c) ? n : c;
        ok     = 1'b1;
        r.n    = n;
        for (int k = 1; k < BUF_DEPTH; k++) begin
            if ((3'(k) < m) && !follower_ok(w[0].data, 2'(k), w[k].data)) ok = 1'b0;
        end
        if (c == 3'd0) r.act = ACT_NONE;
        else if (n == 3'd0 || !ok) r.act = ACT_REPL;
        else if (c >= n) r.act = ACT_PASS;
        else if (last) r.act = ACT_REPL;
        else r.act = ACT_HOLD;
        return r;
    endfunction

endpackage

FILE: rtl/core/utf8v_front.sv
// Front end: takes input bytes, tags each with its lead class and queues
// them (two entries) for the back end. Depends on utf8v_pkg.
module utf8v_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [7:0]           in_byte,
    input  logic                 in_last,
    output logic                 head_valid,
    output utf8v_pkg::item_t     head,
    input  logic                 head_pop
);

    utf8v_pkg::item_t q_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       fill_reg, fill_next;
    logic             push;
    logic             pop;

    assign in_ready   = (fill_reg != 2'd2);
    assign push       = in_valid && in_ready;
    assign head_valid = (fill_reg != 2'd0);
    assign pop        = head_pop && head_valid;
    assign head       = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= '{data: in_byte, last: in_last,
                                   len: utf8v_pkg::lead_length(in_byte)};
        end
    end

endmodule

FILE: rtl/core/utf8v_back.sv
// Back end: scan sequencer over the held bytes plus the queue head,
// emitting output bytes through an output register; it pops no head
// while an item is open. Depends on utf8v_pkg.
module utf8v_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 head_valid,
    input  utf8v_pkg::item_t     head,
    output logic                 head_pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [7:0]           out_byte,
    output logic                 replaced,
    output logic                 run_last,
    output logic                 text_end,
    output logic                 text_valid
);

    utf8v_pkg::st_e                             state_reg, state_next;
    logic                                       busy_reg, busy_next;
    logic [2:0]                                 cnt_reg, cnt_next;
    logic                                       last_reg, last_next;
    logic                                       saw_bad_reg, saw_bad_next;
    logic [1:0]                                 pass_left_reg, pass_left_next;
    utf8v_pkg::entry_t [utf8v_pkg::BUF_DEPTH-1:0] buf_reg, buf_next;

    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg, out_byte_next;
    logic       replaced_reg, replaced_next;
    logic       run_last_reg, run_last_next;
    logic       text_end_reg, text_end_next;
    logic       text_valid_reg, text_valid_next;

    utf8v_pkg::entry_t [utf8v_pkg::BUF_DEPTH-1:0] wb;
    utf8v_pkg::entry_t [utf8v_pkg::BUF_DEPTH-1:0] sb;
    logic [2:0]       wc;
    logic [2:0]       sc;
    logic             wl;
    utf8v_pkg::scan_t cur;
    utf8v_pkg::scan_t rem;
    logic             cur_done;
    logic             rem_done;
    logic             adv;
    logic             emit;
    logic             fin;
    logic [7:0]       e_byte;
    logic             e_rep;
    logic             bad_now;

    assign out_valid  = out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign replaced   = replaced_reg;
    assign run_last   = run_last_reg;
    assign text_end   = text_end_reg;
    assign text_valid = text_valid_reg;

    assign adv = !out_valid_reg || out_ready;

    // working view: held bytes, plus the queue head when no item is open
    always_comb
    begin
        wb = buf_reg;
        if (busy_reg)
        begin
            wc = cnt_reg;
            wl = last_reg;
        end
        else
        begin
            wb[cnt_reg[1:0]] = '{data: head.data, len: head.len};
            wc = cnt_reg + 3'd1;
            wl = head.last;
        end
        sb       = wb;
        sb[2:0]  = wb[3:1];
        sc       = (wc == 3'd0) ? 3'd0 : wc - 3'd1;
        cur      = utf8v_pkg::classify(wb, wc, wl);
        rem      = utf8v_pkg::classify(sb, sc, wl);
        cur_done = (cur.act == utf8v_pkg::ACT_NONE) || (cur.act == utf8v_pkg::ACT_HOLD);
        rem_done = (rem.act == utf8v_pkg::ACT_NONE) || (rem.act == utf8v_pkg::ACT_HOLD);
    end

    always_comb
    begin
        state_next     = state_reg;
        busy_next      = busy_reg;
        cnt_next       = cnt_reg;
        last_next      = last_reg;
        saw_bad_next   = saw_bad_reg;
        pass_left_next = pass_left_reg;
        buf_next       = buf_reg;
        head_pop       = 1'b0;
        emit           = 1'b0;
        fin            = 1'b0;
        e_byte         = out_byte_reg;
        e_rep          = 1'b0;
        bad_now        = 1'b0;

        if (adv)
        begin
            case (state_reg)
                utf8v_pkg::ST_SCAN:
                begin
                    if (busy_reg || head_valid)
                    begin
                        head_pop  = !busy_reg;
                        last_next = wl;
                        case (cur.act)
                            utf8v_pkg::ACT_HOLD:
                            begin
                                buf_next  = wb;
                                cnt_next  = wc;
                                busy_next = 1'b0;
                            end
                            utf8v_pkg::ACT_REPL:
                            begin
                                emit       = 1'b1;
                                e_byte     = utf8v_pkg::REPL_B0;
                                e_rep      = 1'b1;
                                bad_now    = 1'b1;
                                buf_next   = sb;
                                cnt_next   = sc;
                                busy_next  = 1'b1;
                                state_next = utf8v_pkg::ST_REP1;
                            end
                            utf8v_pkg::ACT_PASS:
                            begin
                                emit     = 1'b1;
                                e_byte   = wb[0].data;
                                buf_next = sb;
                                cnt_next = sc;
                                if (cur.n == 3'd1)
                                begin
                                    fin       = rem_done;
                                    busy_next = 1'b1;
                                end
                                else
                                begin
                                    pass_left_next = 2'(cur.n - 3'd1);
                                    busy_next      = 1'b1;
                                    state_next     = utf8v_pkg::ST_PASS;
                                end
                            end
                            default:
                            begin
                                busy_next = 1'b0;
                            end
                        endcase
                    end
                end
                utf8v_pkg::ST_REP1:
                begin
                    emit       = 1'b1;
                    e_byte     = utf8v_pkg::REPL_B1;
                    e_rep      = 1'b1;
                    state_next = utf8v_pkg::ST_REP2;
                end
                utf8v_pkg::ST_REP2:
                begin
                    emit       = 1'b1;
                    e_byte     = utf8v_pkg::REPL_B2;
                    e_rep      = 1'b1;
                    fin        = cur_done;
                    state_next = utf8v_pkg::ST_SCAN;
                end
                utf8v_pkg::ST_PASS:
                begin
                    emit           = 1'b1;
                    e_byte         = wb[0].data;
                    buf_next       = sb;
                    cnt_next       = sc;
                    pass_left_next = pass_left_reg - 2'd1;
                    if (pass_left_reg == 2'd1)
                    begin
                        fin        = rem_done;
                        state_next = utf8v_pkg::ST_SCAN;
                    end
                end
                default:
                begin
                    state_next = utf8v_pkg::ST_SCAN;
                end
            endcase
        end

        if (bad_now)
        begin
            saw_bad_next = 1'b1;
        end

        // item finished: close it, and on end of text drop all state
        if (fin)
        begin
            busy_next  = 1'b0;
            state_next = utf8v_pkg::ST_SCAN;
            if (wl)
            begin
                cnt_next     = 3'd0;
                saw_bad_next = 1'b0;
            end
        end

        out_valid_next  = out_valid_reg;
        out_byte_next   = out_byte_reg;
        replaced_next   = replaced_reg;
        run_last_next   = run_last_reg;
        text_end_next   = text_end_reg;
        text_valid_next = text_valid_reg;
        if (emit)
        begin
            out_valid_next  = 1'b1;
            out_byte_next   = e_byte;
            replaced_next   = e_rep;
            run_last_next   = fin;
            text_end_next   = fin && wl;
            text_valid_next = fin && wl && !(saw_bad_reg || bad_now);
        end
        else if (adv)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= utf8v_pkg::ST_SCAN;
            busy_reg      <= 1'b0;
            cnt_reg       <= 3'd0;
            last_reg      <= 1'b0;
            saw_bad_reg   <= 1'b0;
            pass_left_reg <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            busy_reg      <= busy_next;
            cnt_reg       <= cnt_next;
            last_reg      <= last_next;
            saw_bad_reg   <= saw_bad_next;
            pass_left_reg <= pass_left_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg        <= buf_next;
        out_byte_reg   <= out_byte_next;
        replaced_reg   <= replaced_next;
        run_last_reg   <= run_last_next;
        text_end_reg   <= text_end_next;
        text_valid_reg <= text_valid_next;
    end

    // replacement bytes follow the lead without a gap once taken
    a_rep1_byte: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == utf8v_pkg::ST_REP1 |-> out_valid_reg && replaced_reg
                                           && out_byte_reg == utf8v_pkg::REPL_B0)
        else $error("REP1 without EF lead in output register");

    a_idle_scan: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> state_reg == utf8v_pkg::ST_SCAN && cnt_reg <= 3'd3)
        else $error("closed item left sequencer mid-run or overfilled");

    a_end_marks_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && text_end_reg |-> run_last_reg)
        else $error("text end not on the last result of its byte");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_ready && text_end_reg |-> !busy_reg && cnt_reg == 3'd0)
        else $error("state left over after end of text");

endmodule

FILE: rtl/core/utf8_strict_validate_sanitize.sv
// Top level of the strict UTF-8 validator/sanitizer: front end (tag and
// queue) feeding the scan/emit back end. Depends on utf8v_pkg,
// utf8v_front and utf8v_back.
//
// With the back end idle, the byte that completes a sequence is taken from
// the queue in the next cycle; the sequence's first byte goes straight into
// the output register. Flow: while the output is taken, the back end does
// one step per cycle and ASCII flows at 1 byte/cycle. An n-byte character
// is held while its prefix builds, then emitted byte by byte; each U+FFFD is
// emitted as EF, BF, BD from ST_SCAN, ST_REP1 and ST_REP2. The input stalls
// once the 2-entry queue fills behind a burst.
// Reset: rst_n asynchronous, active low; clears queue, sequencer and output
// valid. Held sequence bytes are not reset (only read below the count).
module utf8_strict_validate_sanitize (
    input  logic       clk,
    input  logic       rst_n,
    // input channel
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    // output channel
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       replaced,
    output logic       run_last,
    output logic       text_end,
    output logic       text_valid
);

    // queue head between the two halves
    logic             head_valid;
    logic             head_pop;
    utf8v_pkg::item_t head;

    // front: accepts bytes, works out each byte's lead class, queues the item
    utf8v_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_byte    (in_byte),
        .in_last    (in_last),
        .head_valid (head_valid),
        .head       (head),
        .head_pop   (head_pop)
    );

    // back: holds partial sequences, checks them strictly, passes good bytes
    // and swaps a failed lead for EF BF BD, rescanning the bytes behind it
    utf8v_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .head_pop   (head_pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .replaced   (replaced),
        .run_last   (run_last),
        .text_end   (text_end),
        .text_valid (text_valid)
    );

endmodule
